// ----- design/assert_macros.svh -----
// assertion macros shared by the allocator rtl
// no dependencies; included by files that hold concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/fcba_pkg.sv -----
// shared types, codes and widths of the fat chain block allocator
// no dependencies; imported by fcba_ctrl, fcba_dp and the top level
package fcba_pkg;

    localparam int LINK_W    = 12;
    localparam int BLK_W     = 11;
    localparam int CFG_AW    = 1;
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 2;

    localparam logic [LINK_W-1:0] RESV_MARK    = 12'hFFF;
    localparam logic [LINK_W-1:0] RESERVED_RST = 12'd44;
    localparam logic [LINK_W-1:0] TOTAL_RST    = 12'd2048;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_RESERVED = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_TOTAL    = 1'b1;

    typedef enum logic [1:0] {
        FUNC_FORMAT = 2'd0,
        FUNC_ALLOC  = 2'd1,
        FUNC_NEXT   = 2'd2,
        FUNC_TAIL   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NO_FREE = 2'd1,
        STAT_BAD     = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        SRC_ZERO,
        SRC_RDATA,
        SRC_CUR,
        SRC_NXT,
        SRC_HEAD
    } res_src_t;

    // controller to datapath
    typedef struct packed {
        logic     latch_in;
        logic     sweep_clear;
        logic     sweep_format;
        logic     fmt_finish;
        logic     rd_head;
        logic     pop_commit;
        logic     rd_blk;
        logic     link_blk;
        logic     walk_init;
        logic     rd_nxt;
        logic     walk_adv;
        logic     set_result;
        res_src_t res_src;
        status_t  res_status;
        logic     load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic count_zero;
        logic blk_bad;
        logic rd_resv;
        logic rd_zero;
        logic nxt_zero;
        logic nxt_bad;
        logic sweep_last;
        logic steps_last;
        logic out_free;
    } dp_stat_t;

endpackage

// ----- design/fcba_ram.sv -----
// generic simple dual-port ram with registered read
// no dependencies
module fcba_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/fcba_ctrl.sv -----
// operation sequencer of the fat chain block allocator
// depends on fcba_pkg; drives the datapath through cmd_t
module fcba_ctrl import fcba_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  func_t    in_func,
    input  dp_stat_t dp_stat,
    output cmd_t     cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FORMAT,
        ST_POP_RD,
        ST_POP_WR,
        ST_CHK_RD,
        ST_CHK_EVAL,
        ST_WALK,
        ST_WALK_EVAL,
        ST_RESULT
    } state_t;

    state_t state_reg, state_next;
    func_t  func_reg, func_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            func_reg  <= FUNC_FORMAT;
        end else begin
            state_reg <= state_next;
            func_reg  <= func_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        func_next  = func_reg;
        cmd        = '0;
        cmd.res_src    = SRC_ZERO;
        cmd.res_status = STAT_OK;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.sweep_clear = 1'b1;
                if (dp_stat.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch_in = 1'b1;
                    func_next    = in_func;
                    unique case (in_func)
                        FUNC_FORMAT: state_next = ST_FORMAT;
                        FUNC_ALLOC:  state_next = ST_POP_RD;
                        default:     state_next = ST_CHK_RD;
                    endcase
                end
            end
            ST_FORMAT: begin
                cmd.sweep_format = 1'b1;
                if (dp_stat.sweep_last) begin
                    cmd.fmt_finish = 1'b1;
                    cmd.set_result = 1'b1;
                    state_next     = ST_RESULT;
                end
            end
            ST_POP_RD: begin
                if (dp_stat.count_zero) begin
                    cmd.set_result = 1'b1;
                    cmd.res_status = STAT_NO_FREE;
                    state_next     = ST_RESULT;
                end else begin
                    cmd.rd_head = 1'b1;
                    state_next  = ST_POP_WR;
                end
            end
            ST_POP_WR: begin
                cmd.pop_commit = 1'b1;
                cmd.set_result = 1'b1;
                cmd.res_src    = SRC_HEAD;
                state_next     = ST_RESULT;
            end
            ST_CHK_RD: begin
                if (dp_stat.blk_bad) begin
                    cmd.set_result = 1'b1;
                    cmd.res_status = STAT_BAD;
                    state_next     = ST_RESULT;
                end else begin
                    cmd.rd_blk = 1'b1;
                    state_next = ST_CHK_EVAL;
                end
            end
            ST_CHK_EVAL: begin
                if (dp_stat.rd_resv) begin
                    cmd.set_result = 1'b1;
                    cmd.res_status = STAT_BAD;
                    state_next     = ST_RESULT;
                end else if (func_reg == FUNC_NEXT) begin
                    if (!dp_stat.rd_zero) begin
                        cmd.set_result = 1'b1;
                        cmd.res_src    = SRC_RDATA;
                        state_next     = ST_RESULT;
                    end else if (dp_stat.count_zero) begin
                        cmd.set_result = 1'b1;
                        cmd.res_status = STAT_NO_FREE;
                        state_next     = ST_RESULT;
                    end else begin
                        cmd.link_blk = 1'b1;
                        state_next   = ST_POP_RD;
                    end
                end else begin
                    cmd.walk_init = 1'b1;
                    state_next    = ST_WALK;
                end
            end
            ST_WALK: begin
                if (dp_stat.nxt_zero) begin
                    cmd.set_result = 1'b1;
                    cmd.res_src    = SRC_CUR;
                    state_next     = ST_RESULT;
                end else if (dp_stat.nxt_bad) begin
                    cmd.set_result = 1'b1;
                    cmd.res_status = STAT_BAD;
                    state_next     = ST_RESULT;
                end else begin
                    cmd.rd_nxt = 1'b1;
                    state_next = ST_WALK_EVAL;
                end
            end
            ST_WALK_EVAL: begin
                if (dp_stat.rd_resv) begin
                    cmd.set_result = 1'b1;
                    cmd.res_status = STAT_BAD;
                    state_next     = ST_RESULT;
                end else begin
                    cmd.walk_adv = 1'b1;
                    if (dp_stat.steps_last) begin
                        cmd.set_result = 1'b1;
                        cmd.res_src    = SRC_NXT;
                        state_next     = ST_RESULT;
                    end else begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_RESULT: begin
                if (dp_stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/fcba_dp.sv -----
// link table, free list registers and result register of the allocator
// depends on fcba_pkg and fcba_ram; steered by fcba_ctrl through cmd_t
module fcba_dp import fcba_pkg::*; #(
    parameter int TABLE_ENTRIES = 2048
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_AW-1:0]     cfg_addr,
    input  logic [LINK_W-1:0]     cfg_wdata,
    input  logic [BLK_W-1:0]      in_block,
    input  cmd_t                  cmd,
    output dp_stat_t              dp_stat,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic [M_TUSER_W-1:0]  m_tuser
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = (AW + 1 > LINK_W + 1) ? AW + 1 : LINK_W + 1;
    localparam int SW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] TBL_CW    = CW'(TABLE_ENTRIES);
    localparam logic [AW-1:0] SWEEP_END = AW'(TABLE_ENTRIES - 1);
    localparam logic [SW-1:0] STEPS_END = SW'(TABLE_ENTRIES - 1);

    logic [LINK_W-1:0] reserved_reg, total_reg;
    logic [BLK_W-1:0]  head_reg;
    logic [LINK_W-1:0] count_reg;
    logic [AW-1:0]     sweep_reg;
    logic              m_valid_reg;
    logic [BLK_W-1:0]  blk_reg, cur_reg, res_reg, m_res_reg;
    logic [LINK_W-1:0] nxt_reg, m_free_reg;
    logic [SW-1:0]     steps_reg;
    logic              rd_ok_reg;
    status_t           st_reg, m_st_reg;

    logic [LINK_W-1:0] t_eff, r_eff;
    logic [LINK_W-1:0] rdata_raw, rdata;
    logic [LINK_W-1:0] rd_idx, wr_idx, ram_wdata, fmt_value;
    logic [CW-1:0]     rd_cw, wr_cw, sweep_cw;
    logic              rd_in_range, wr_req, wr_sweep, ram_we;
    logic [AW-1:0]     ram_raddr, ram_waddr;
    logic [BLK_W-1:0]  res_value;

    // clamp registers to the table and reserved to total
    always_comb begin
        t_eff = (CW'(total_reg) > TBL_CW) ? LINK_W'(TBL_CW) : total_reg;
        r_eff = (reserved_reg > t_eff) ? t_eff : reserved_reg;
    end

    // read port: entries beyond the table read as zero
    always_comb begin
        if (cmd.rd_head) begin
            rd_idx = {1'b0, head_reg};
        end else if (cmd.rd_blk) begin
            rd_idx = {1'b0, blk_reg};
        end else if (cmd.rd_nxt) begin
            rd_idx = nxt_reg;
        end else begin
            rd_idx = nxt_reg;
        end
        rd_cw       = CW'(rd_idx);
        rd_in_range = rd_cw < TBL_CW;
        ram_raddr   = rd_cw[AW-1:0];
    end

    assign rdata = rd_ok_reg ? rdata_raw : '0;

    // format pattern at the sweep position
    always_comb begin
        sweep_cw = CW'(sweep_reg);
        if (sweep_cw < CW'(r_eff)) begin
            fmt_value = RESV_MARK;
        end else if (sweep_cw >= CW'(t_eff) || (sweep_cw + CW'(1)) == CW'(t_eff)) begin
            fmt_value = '0;
        end else begin
            fmt_value = LINK_W'(sweep_cw + CW'(1));
        end
    end

    // write port: sweeps, chain link or clearing a popped entry
    always_comb begin
        wr_idx    = {1'b0, head_reg};
        ram_wdata = '0;
        wr_req    = 1'b0;
        wr_sweep  = 1'b0;
        if (cmd.sweep_clear) begin
            wr_sweep = 1'b1;
        end else if (cmd.sweep_format) begin
            wr_sweep  = 1'b1;
            ram_wdata = fmt_value;
        end else if (cmd.link_blk) begin
            wr_req    = 1'b1;
            wr_idx    = {1'b0, blk_reg};
            ram_wdata = {1'b0, head_reg};
        end else if (cmd.pop_commit) begin
            wr_req = 1'b1;
        end
        wr_cw     = CW'(wr_idx);
        ram_we    = wr_sweep | (wr_req & (wr_cw < TBL_CW));
        ram_waddr = wr_sweep ? sweep_reg : wr_cw[AW-1:0];
    end

    fcba_ram #(
        .WIDTH (LINK_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rdata_raw)
    );

    always_comb begin
        case (cmd.res_src)
            SRC_RDATA: res_value = rdata[BLK_W-1:0];
            SRC_CUR:   res_value = cur_reg;
            SRC_NXT:   res_value = nxt_reg[BLK_W-1:0];
            SRC_HEAD:  res_value = head_reg;
            default:   res_value = '0;
        endcase
    end

    always_comb begin
        dp_stat.count_zero = (count_reg == '0);
        dp_stat.blk_bad    = ({1'b0, blk_reg} >= t_eff) || ({1'b0, blk_reg} < r_eff);
        dp_stat.rd_resv    = (rdata == RESV_MARK);
        dp_stat.rd_zero    = (rdata == '0);
        dp_stat.nxt_zero   = (nxt_reg == '0);
        dp_stat.nxt_bad    = (nxt_reg >= t_eff) || (nxt_reg < r_eff);
        dp_stat.sweep_last = (sweep_reg == SWEEP_END);
        dp_stat.steps_last = (steps_reg == STEPS_END);
        dp_stat.out_free   = !m_valid_reg || m_tready;
    end

    // architectural state and control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reserved_reg <= RESERVED_RST;
            total_reg    <= TOTAL_RST;
            head_reg     <= '0;
            count_reg    <= '0;
            sweep_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_RESERVED: reserved_reg <= cfg_wdata;
                    CFG_TOTAL:    total_reg    <= cfg_wdata;
                    default:      ;
                endcase
            end
            if (cmd.sweep_clear || cmd.sweep_format) begin
                sweep_reg <= dp_stat.sweep_last ? '0 : sweep_reg + AW'(1);
            end
            if (cmd.fmt_finish) begin
                count_reg <= t_eff - r_eff;
                head_reg  <= (r_eff < t_eff) ? r_eff[BLK_W-1:0] : '0;
            end else if (cmd.pop_commit) begin
                count_reg <= count_reg - LINK_W'(1);
                head_reg  <= rdata[BLK_W-1:0];
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        rd_ok_reg <= rd_in_range;
        if (cmd.latch_in) begin
            blk_reg <= in_block;
        end
        if (cmd.walk_init) begin
            cur_reg   <= blk_reg;
            nxt_reg   <= rdata;
            steps_reg <= '0;
        end else if (cmd.walk_adv) begin
            cur_reg   <= nxt_reg[BLK_W-1:0];
            nxt_reg   <= rdata;
            steps_reg <= steps_reg + SW'(1);
        end
        if (cmd.set_result) begin
            res_reg <= res_value;
            st_reg  <= cmd.res_status;
        end
        if (cmd.load_out) begin
            m_res_reg  <= res_reg;
            m_st_reg   <= st_reg;
            m_free_reg <= count_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - LINK_W - BLK_W){1'b0}}, m_free_reg, m_res_reg};
    assign m_tuser  = m_st_reg;

endmodule

// ----- design/fat_chain_block_allocator.sv -----
// top level of the fat chain block allocator
// depends on fcba_pkg, fcba_ctrl, fcba_dp, fcba_ram and assert_macros.svh

// A file allocation table of next-block links with the free list threaded
// through it. After reset the block sweeps the table to zero, one entry per
// cycle, and takes no operation until the sweep is done; configuration
// writes are taken at any time. The table lives in one ram with a registered
// read port, so every table lookup presents its address and then takes its
// data from that register. Alloc pops the free head (or reports that no
// block is free), next returns a stored successor or extends the chain with
// a popped block, find tail follows the links of a chain, and format sweeps
// the whole table; errors found on the range check end the operation before
// any table read. One item is in work at a time; the next one can be accepted
// as soon as the result enters the output register, even while that result
// still waits to be taken.
module fat_chain_block_allocator import fcba_pkg::*; #(
    parameter int TABLE_ENTRIES = 2048
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration writes: 0 reserved_blocks, 1 total_blocks
    input  logic                  cfg_wr_en,
    input  logic [CFG_AW-1:0]     cfg_addr,
    input  logic [LINK_W-1:0]     cfg_wdata,
    // operation input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // block[10:0], zero fill
    input  logic [S_TUSER_W-1:0]  s_tuser,   // func[1:0]
    // result output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // result_block[10:0], free_left[22:11], zero fill
    output logic [M_TUSER_W-1:0]  m_tuser    // status[1:0]
);

    cmd_t     cmd;
    dp_stat_t dp_stat;

    // sequencer: walks each operation through table reads and writes
    fcba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_func  (func_t'(s_tuser)),
        .dp_stat  (dp_stat),
        .cmd      (cmd)
    );

    // table, free head, free count, config and output register
    fcba_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_block  (s_tdata[BLK_W-1:0]),
        .cmd       (cmd),
        .dp_stat   (dp_stat),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

`include "assert_macros.svh"

    // a finished result never overwrites one still waiting
    `ASSERT_IMPL(a_no_result_overwrite, aclk, aresetn, cmd.load_out, dp_stat.out_free, "result register overwritten")

    // an accepted operation needs table work before its result
    `ASSERT_NEXT(a_no_instant_result, aclk, aresetn, s_tvalid && s_tready, !cmd.load_out, "result loaded right after accept")

    // any error reports block zero
    `ASSERT_IMPL(a_error_zero_block, aclk, aresetn, m_tvalid && (m_tuser != STAT_OK), m_tdata[BLK_W-1:0] == '0, "error result with nonzero block")

    // free count stays within the table
    `ASSERT_IMPL(a_free_in_range, aclk, aresetn, m_tvalid, int'(m_tdata[BLK_W +: LINK_W]) <= TABLE_ENTRIES, "free count above table size")

endmodule
